// File: hw/rtl/abbt_pkg.sv
// ----------------------------------------------------------------------------
// abbt_pkg
// Shared types and constants for the transformed bounding box block.
// ----------------------------------------------------------------------------
package abbt_pkg;

    localparam int FRACTION_BITS_DEFAULT = 16;
    localparam int NUM_AXES              = 3;
    localparam int NUM_REGS              = 6;
    localparam int CFG_INDEX_W           = 3;
    localparam int CFG_DATA_W            = 64;
    localparam int COORD_W               = 32;
    localparam int PROD_W                = 2 * COORD_W;
    localparam int SUM_W                 = PROD_W + 2;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_X_COLS_01 = 3'd0,
        REG_ROW_X_COLS_23 = 3'd1,
        REG_ROW_Y_COLS_01 = 3'd2,
        REG_ROW_Y_COLS_23 = 3'd3,
        REG_ROW_Z_COLS_01 = 3'd4,
        REG_ROW_Z_COLS_23 = 3'd5
    } reg_index_t;

    localparam cfg_data_t RESET_ROW_X_COLS_01 = 64'h0000_0000_0001_0000;
    localparam cfg_data_t RESET_ROW_X_COLS_23 = 64'h0000_0000_0000_0000;
    localparam cfg_data_t RESET_ROW_Y_COLS_01 = 64'h0001_0000_0000_0000;
    localparam cfg_data_t RESET_ROW_Y_COLS_23 = 64'h0000_0000_0000_0000;
    localparam cfg_data_t RESET_ROW_Z_COLS_01 = 64'h0000_0000_0000_0000;
    localparam cfg_data_t RESET_ROW_Z_COLS_23 = 64'h0000_0000_0001_0000;

endpackage

// File: hw/rtl/affine_bounding_box_transform.sv
// ----------------------------------------------------------------------------
// affine_bounding_box_transform
// Maps an axis-aligned box through an affine matrix and bounds the result.
//
// An input word carries the minimum and maximum corners of an object-space
// box in signed fixed point. The result word carries the per-axis minimum
// and maximum of the eight corners mapped through the top three rows of the
// configured matrix, floored to the output grid and saturated to 32 bits.
// The six matrix registers are written through the cfg channel, which is
// always ready; writes must happen while no box is in flight.
// The pipeline has five register stages: products, per-term min and max,
// a partial sum, the full sum, and the shift, translation and saturation.
// m_valid rises once a box has passed the last stage, and one box is
// taken every cycle unless backpressure holds s_ready low. Each stage
// holds its word while the next one is full, so a stalled receiver fills
// the bubbles first and backpressure then reaches s_ready; nothing is
// dropped or repeated. Synchronous reset empties the pipeline and loads
// the identity matrix.
// ----------------------------------------------------------------------------
module affine_bounding_box_transform #(
    parameter int FRACTION_BITS = abbt_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  abbt_pkg::coord_t     s_box_low_x,
    input  abbt_pkg::coord_t     s_box_low_y,
    input  abbt_pkg::coord_t     s_box_low_z,
    input  abbt_pkg::coord_t     s_box_high_x,
    input  abbt_pkg::coord_t     s_box_high_y,
    input  abbt_pkg::coord_t     s_box_high_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output abbt_pkg::coord_t     m_world_low_x,
    output abbt_pkg::coord_t     m_world_low_y,
    output abbt_pkg::coord_t     m_world_low_z,
    output abbt_pkg::coord_t     m_world_high_x,
    output abbt_pkg::coord_t     m_world_high_y,
    output abbt_pkg::coord_t     m_world_high_z,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  abbt_pkg::cfg_index_t cfg_index,
    input  abbt_pkg::cfg_data_t  cfg_data
);
    import abbt_pkg::*;

    cfg_data_t cfg_reg [NUM_REGS];

    coord_t coef [NUM_AXES][NUM_AXES];
    coord_t trans [NUM_AXES];
    coord_t box_lo [NUM_AXES];
    coord_t box_hi [NUM_AXES];

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    prod_t prod_lo_reg [NUM_AXES][NUM_AXES];
    prod_t prod_hi_reg [NUM_AXES][NUM_AXES];
    prod_t pmin_reg [NUM_AXES][NUM_AXES];
    prod_t pmax_reg [NUM_AXES][NUM_AXES];
    sum_t  part_min_reg [NUM_AXES];
    sum_t  part_max_reg [NUM_AXES];
    prod_t rest_min_reg [NUM_AXES];
    prod_t rest_max_reg [NUM_AXES];
    sum_t  sum_min_reg [NUM_AXES];
    sum_t  sum_max_reg [NUM_AXES];
    coord_t out_min_reg [NUM_AXES];
    coord_t out_max_reg [NUM_AXES];
    coord_t out_min_next [NUM_AXES];
    coord_t out_max_next [NUM_AXES];

    function automatic coord_t finish(sum_t s, coord_t t);
        sum_t shifted;
        sum_t total;
        shifted = s >>> FRACTION_BITS;
        total   = shifted + sum_t'(t);
        if (total[SUM_W-1:COORD_W-1] == '0 || total[SUM_W-1:COORD_W-1] == '1) begin
            return total[COORD_W-1:0];
        end else if (total[SUM_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[REG_ROW_X_COLS_01] <= RESET_ROW_X_COLS_01;
            cfg_reg[REG_ROW_X_COLS_23] <= RESET_ROW_X_COLS_23;
            cfg_reg[REG_ROW_Y_COLS_01] <= RESET_ROW_Y_COLS_01;
            cfg_reg[REG_ROW_Y_COLS_23] <= RESET_ROW_Y_COLS_23;
            cfg_reg[REG_ROW_Z_COLS_01] <= RESET_ROW_Z_COLS_01;
            cfg_reg[REG_ROW_Z_COLS_23] <= RESET_ROW_Z_COLS_23;
        end else if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_ROW_X_COLS_01: cfg_reg[REG_ROW_X_COLS_01] <= cfg_data;
                REG_ROW_X_COLS_23: cfg_reg[REG_ROW_X_COLS_23] <= cfg_data;
                REG_ROW_Y_COLS_01: cfg_reg[REG_ROW_Y_COLS_01] <= cfg_data;
                REG_ROW_Y_COLS_23: cfg_reg[REG_ROW_Y_COLS_23] <= cfg_data;
                REG_ROW_Z_COLS_01: cfg_reg[REG_ROW_Z_COLS_01] <= cfg_data;
                REG_ROW_Z_COLS_23: cfg_reg[REG_ROW_Z_COLS_23] <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            coef[a][0] = cfg_reg[2*a][COORD_W-1:0];
            coef[a][1] = cfg_reg[2*a][CFG_DATA_W-1:COORD_W];
            coef[a][2] = cfg_reg[2*a+1][COORD_W-1:0];
            trans[a]   = cfg_reg[2*a+1][CFG_DATA_W-1:COORD_W];
        end
        box_lo[0] = s_box_low_x;
        box_lo[1] = s_box_low_y;
        box_lo[2] = s_box_low_z;
        box_hi[0] = s_box_high_x;
        box_hi[1] = s_box_high_y;
        box_hi[2] = s_box_high_z;
    end

    // Each stage loads when it is empty or its successor takes its word.
    assign rdy5    = !v5_reg || m_ready;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            out_min_next[a] = finish(sum_min_reg[a], trans[a]);
            out_max_next[a] = finish(sum_max_reg[a], trans[a]);
        end
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (rdy1 && s_valid) begin
                for (int j = 0; j < NUM_AXES; j++) begin
                    prod_lo_reg[a][j] <= prod_t'(coef[a][j]) * prod_t'(box_lo[j]);
                    prod_hi_reg[a][j] <= prod_t'(coef[a][j]) * prod_t'(box_hi[j]);
                end
            end
            if (rdy2 && v1_reg) begin
                for (int j = 0; j < NUM_AXES; j++) begin
                    if (prod_lo_reg[a][j] < prod_hi_reg[a][j]) begin
                        pmin_reg[a][j] <= prod_lo_reg[a][j];
                        pmax_reg[a][j] <= prod_hi_reg[a][j];
                    end else begin
                        pmin_reg[a][j] <= prod_hi_reg[a][j];
                        pmax_reg[a][j] <= prod_lo_reg[a][j];
                    end
                end
            end
            if (rdy3 && v2_reg) begin
                part_min_reg[a] <= sum_t'(pmin_reg[a][0]) + sum_t'(pmin_reg[a][1]);
                part_max_reg[a] <= sum_t'(pmax_reg[a][0]) + sum_t'(pmax_reg[a][1]);
                rest_min_reg[a] <= pmin_reg[a][2];
                rest_max_reg[a] <= pmax_reg[a][2];
            end
            if (rdy4 && v3_reg) begin
                sum_min_reg[a] <= part_min_reg[a] + sum_t'(rest_min_reg[a]);
                sum_max_reg[a] <= part_max_reg[a] + sum_t'(rest_max_reg[a]);
            end
            if (rdy5 && v4_reg) begin
                out_min_reg[a] <= out_min_next[a];
                out_max_reg[a] <= out_max_next[a];
            end
        end
    end

    assign m_valid        = v5_reg;
    assign m_world_low_x  = out_min_reg[0];
    assign m_world_low_y  = out_min_reg[1];
    assign m_world_low_z  = out_min_reg[2];
    assign m_world_high_x = out_max_reg[0];
    assign m_world_high_y = out_max_reg[1];
    assign m_world_high_z = out_max_reg[2];

endmodule

// File: hw/rtl/abbt_checker.sv
// ----------------------------------------------------------------------------
// abbt_checker
// Port-level checks for the transformed bounding box block.
// ----------------------------------------------------------------------------
module abbt_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input abbt_pkg::coord_t     m_world_low_x,
    input abbt_pkg::coord_t     m_world_low_y,
    input abbt_pkg::coord_t     m_world_low_z,
    input abbt_pkg::coord_t     m_world_high_x,
    input abbt_pkg::coord_t     m_world_high_y,
    input abbt_pkg::coord_t     m_world_high_z
);

    // A result word never appears in the cycle right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    // A receiver that takes every word never stalls the sender.
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is ready");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_world_low_x) && $stable(m_world_high_x)
            && $stable(m_world_low_y) && $stable(m_world_high_y)
            && $stable(m_world_low_z) && $stable(m_world_high_z))
        else $error("result word changed while stalled");

endmodule

bind affine_bounding_box_transform abbt_checker u_abbt_checker (.*);
